FILE: hw/rtl/rits_pkg.sv
`default_nettype none

package rits_pkg;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [1:0] REG_RADIX     = 2'd0;
   localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
   localparam logic [1:0] REG_MODE      = 2'd2;

   localparam logic [5:0]  RADIX_RESET     = 6'd10;
   localparam logic [15:0] MAX_WIDTH_RESET = 16'hFFFF;
   localparam logic [1:0]  MODE_RESET      = 2'd1;

   // Result modes.
   localparam logic [1:0] MODE_RAW      = 2'd0;
   localparam logic [1:0] MODE_UNSIGNED = 2'd1;
   localparam logic [1:0] MODE_INT      = 2'd2;

   // Largest radix that still works, and the signed int limits.
   localparam logic [5:0]  RADIX_LIMIT = 6'd36;
   localparam logic [63:0] INT_POS_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] INT_NEG_MAG = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [5:0]  radix;
      logic [15:0] max_field_width;
      logic [1:0]  result_mode;
   } cfg_type;

   // Everything about a finished scan except the accumulator itself.
   typedef struct packed {
      logic        ok;
      logic        minus;
      logic        overflow;
      logic        at_end;
      logic [7:0]  stop_char;
      logic [15:0] count;
   } scan_info_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rits_csr.sv
`default_nettype none

module rits_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output rits_pkg::cfg_type     cfg
);

   rits_pkg::cfg_type cfg_ff;
   rits_pkg::cfg_type cfg_in;
   logic              write_en;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_paddr[3:2])
            rits_pkg::REG_RADIX:     cfg_in.radix           = csr_pwdata[5:0];
            rits_pkg::REG_MAX_WIDTH: cfg_in.max_field_width = csr_pwdata[15:0];
            rits_pkg::REG_MODE:      cfg_in.result_mode     = csr_pwdata[1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         rits_pkg::REG_RADIX:     csr_prdata = {26'd0, cfg_ff.radix};
         rits_pkg::REG_MAX_WIDTH: csr_prdata = {16'd0, cfg_ff.max_field_width};
         rits_pkg::REG_MODE:      csr_prdata = {30'd0, cfg_ff.result_mode};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix           <= rits_pkg::RADIX_RESET;
         cfg_ff.max_field_width <= rits_pkg::MAX_WIDTH_RESET;
         cfg_ff.result_mode     <= rits_pkg::MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rits_scan.sv
`default_nettype none

module rits_scan #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [7:0]             char_code,
   input  wire logic                   at_end,
   input  wire logic [5:0]             radix,
   input  wire logic [15:0]            max_field_width,
   output logic                        emit,
   output rits_pkg::scan_info_type     info,
   output logic [VALUE_WIDTH-1:0]      acc_value
);

   localparam logic [2:0] PH_START      = 3'd0;
   localparam logic [2:0] PH_CHECK_ZERO = 3'd1;
   localparam logic [2:0] PH_LEAD_ZERO  = 3'd2;
   localparam logic [2:0] PH_NEED_DIGIT = 3'd3;
   localparam logic [2:0] PH_DIGIT_LOOP = 3'd4;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [6:0] NO_DIGIT = 7'd99;

   localparam int PROD_WIDTH = VALUE_WIDTH + 6;
   localparam int SUM_WIDTH  = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

   // Digit value of a character, or a value above every radix if it is none.
   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [6:0] d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 7'(c - CH_ZERO);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = 7'(c - CH_UP_A) + 7'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = 7'(c - CH_LO_A) + 7'd10;
      end else begin
         d = NO_DIGIT;
      end
      return d;
   endfunction

   logic [2:0]             phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [5:0]             eff_ff, eff_in;
   logic                   minus_ff, minus_in;
   logic                   ovf_ff, ovf_in;
   logic [15:0]            ns_ff, ns_in;
   logic [COUNT_WIDTH-1:0] sp_ff, sp_in;

   logic                   first_item;
   logic                   is_space;
   logic [6:0]             dval;
   logic                   step_emit;
   logic                   step_ok;
   logic                   more;
   logic [PROD_WIDTH-1:0]  prod;
   logic [VALUE_WIDTH:0]   sum;
   logic [SUM_WIDTH-1:0]   count_sum;
   logic [SUM_WIDTH-1:0]   count_max;
   logic [SUM_WIDTH-1:0]   count_sat;

   assign first_item = (phase_ff == PH_START) && (sp_ff == '0);
   assign is_space   = (char_code == CH_SPACE) ||
                       (char_code >= CH_TAB && char_code <= CH_CR);
   assign dval       = digit_value(char_code);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      eff_in    = first_item ? radix : eff_ff;
      minus_in  = minus_ff;
      ovf_in    = ovf_ff;
      ns_in     = ns_ff;
      sp_in     = sp_ff;
      step_emit = 1'b0;
      step_ok   = 1'b0;
      more      = 1'b1;
      prod      = '0;
      sum       = '0;

      if (first_item && (radix == 6'd1 || radix > rits_pkg::RADIX_LIMIT)) begin
         step_emit = 1'b1;
      end else if (at_end || ns_ff >= max_field_width) begin
         step_emit = 1'b1;
         step_ok   = (phase_ff == PH_LEAD_ZERO) || (phase_ff == PH_DIGIT_LOOP);
      end else begin
         if (phase_in == PH_START) begin
            if (is_space) begin
               if (sp_ff != '1) begin
                  sp_in = sp_ff + 1'b1;
               end
               more = 1'b0;
            end else begin
               phase_in = PH_CHECK_ZERO;
               if (char_code == CH_PLUS || char_code == CH_MINUS) begin
                  minus_in = (char_code == CH_MINUS);
                  ns_in    = ns_ff + 16'd1;
                  more     = 1'b0;
               end
            end
         end
         if (more && phase_in == PH_CHECK_ZERO) begin
            if ((eff_in == 6'd0 || eff_in == 6'd16) && char_code == CH_ZERO) begin
               phase_in = PH_LEAD_ZERO;
               ns_in    = ns_ff + 16'd1;
               more     = 1'b0;
            end else begin
               phase_in = PH_NEED_DIGIT;
            end
         end
         if (more && phase_in == PH_LEAD_ZERO) begin
            if (char_code == CH_UP_X || char_code == CH_LO_X) begin
               eff_in   = 6'd16;
               phase_in = PH_NEED_DIGIT;
               ns_in    = ns_ff + 16'd1;
               more     = 1'b0;
            end else begin
               if (eff_in == 6'd0) begin
                  eff_in = 6'd8;
               end
               phase_in = PH_DIGIT_LOOP;
            end
         end
         if (more) begin
            if (phase_in != PH_NEED_DIGIT && phase_in != PH_DIGIT_LOOP) begin
               phase_in = PH_NEED_DIGIT;
            end
            if (eff_in == 6'd0) begin
               eff_in = 6'd10;
            end
            if (dval >= {1'b0, eff_in}) begin
               step_emit = 1'b1;
               step_ok   = (phase_in == PH_DIGIT_LOOP);
            end else begin
               // Multiply-add; any bit above the value width marks overflow.
               prod = PROD_WIDTH'(acc_ff) * PROD_WIDTH'(eff_in);
               sum  = {1'b0, prod[VALUE_WIDTH-1:0]} + (VALUE_WIDTH + 1)'(dval);
               if ((|prod[PROD_WIDTH-1:VALUE_WIDTH]) || sum[VALUE_WIDTH]) begin
                  ovf_in = 1'b1;
               end
               acc_in   = sum[VALUE_WIDTH-1:0];
               phase_in = PH_DIGIT_LOOP;
               ns_in    = ns_ff + 16'd1;
            end
         end
      end

      // A finished scan starts the next one from scratch.
      if (step_emit) begin
         phase_in = PH_START;
         acc_in   = '0;
         eff_in   = radix;
         minus_in = 1'b0;
         ovf_in   = 1'b0;
         ns_in    = '0;
         sp_in    = '0;
      end
   end

   assign count_sum = SUM_WIDTH'(ns_ff) + SUM_WIDTH'(sp_ff);
   assign count_max = SUM_WIDTH'({COUNT_WIDTH{1'b1}});
   assign count_sat = (count_sum > count_max) ? count_max : count_sum;

   assign emit           = step_emit;
   assign acc_value      = acc_ff;
   assign info.ok        = step_ok;
   assign info.minus     = minus_ff;
   assign info.overflow  = step_ok && ovf_ff;
   assign info.at_end    = at_end;
   assign info.stop_char = at_end ? 8'd0 : char_code;
   assign info.count     = step_ok ? 16'(count_sat) : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         acc_ff   <= '0;
         eff_ff   <= rits_pkg::RADIX_RESET;
         minus_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         ns_ff    <= '0;
         sp_ff    <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         eff_ff   <= eff_in;
         minus_ff <= minus_in;
         ovf_ff   <= ovf_in;
         ns_ff    <= ns_in;
         sp_ff    <= sp_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rits_convert.sv
`default_nettype none

module rits_convert #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic [VALUE_WIDTH-1:0]      acc_value,
   input  wire rits_pkg::scan_info_type     info,
   input  wire logic [1:0]                  result_mode,
   output logic [31:0]                      raw_magnitude,
   output logic [31:0]                      converted_value,
   output logic                             range_error
);

   logic [VALUE_WIDTH-1:0] raw_vw;
   logic [VALUE_WIDTH-1:0] neg_vw;
   logic [63:0]            raw_wide;
   logic [63:0]            conv_wide;

   assign raw_vw   = info.ok ? acc_value : '0;
   assign neg_vw   = '0 - raw_vw;
   assign raw_wide = 64'(raw_vw);

   always_comb begin
      conv_wide   = raw_wide;
      range_error = 1'b0;
      case (result_mode)
         rits_pkg::MODE_UNSIGNED: begin
            if (info.overflow) begin
               conv_wide   = 64'({VALUE_WIDTH{1'b1}});
               range_error = 1'b1;
            end else if (info.minus) begin
               conv_wide = 64'(neg_vw);
            end
         end
         rits_pkg::MODE_INT: begin
            if (info.overflow ||
                (!info.minus && raw_wide > rits_pkg::INT_POS_MAX) ||
                (info.minus && raw_wide > rits_pkg::INT_NEG_MAG)) begin
               conv_wide   = info.minus ? rits_pkg::INT_NEG_MAG : rits_pkg::INT_POS_MAX;
               range_error = 1'b1;
            end else if (info.minus) begin
               conv_wide = 64'(32'd0 - raw_wide[31:0]);
            end
         end
         default: begin
            conv_wide   = raw_wide;
            range_error = 1'b0;
         end
      endcase
   end

   assign raw_magnitude   = raw_wide[31:0];
   assign converted_value = conv_wide[31:0];

endmodule

`default_nettype wire

FILE: hw/rtl/radix_integer_text_scanner.sv
// The item that ends a scan is held in the input register, and its result is offered from the result register.
// Throughput: one item per cycle unless a stalled result blocks the result register; the multiply-add feeds back.
// Items that do not end a scan give no result and leave only the scan state changed.
// Reset is synchronous and active high: it clears the scan state, empties both registers
// and loads the register defaults (radix 10, field width 65535, unsigned mode).
`default_nettype none

module radix_integer_text_scanner #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_no_more_chars,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_raw_magnitude,
   output logic [31:0]      rsp_converted_value,
   output logic             rsp_sign_seen,
   output logic             rsp_overflowed,
   output logic             rsp_range_error,
   output logic             rsp_valid_number,
   output logic [15:0]      rsp_chars_consumed,
   output logic [7:0]       rsp_stop_char,
   output logic             rsp_stopped_at_end,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // The block is two registers with the scanner between them. The input
   // register holds one item; the scanner consumes it when the result
   // register can take whatever the item produces, which is whenever that
   // register is empty or is being emptied this cycle.

   rits_pkg::cfg_type       cfg;
   rits_pkg::scan_info_type info;
   logic [VALUE_WIDTH-1:0]  acc_value;
   logic                    emit;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_end_ff;
   logic        accept;
   logic        advance;
   logic        fire;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] raw_ff, conv_ff;
   logic        sign_ff, ovf_ff, range_ff, ok_ff, end_ff;
   logic [15:0] count_ff;
   logic [7:0]  stop_ff;

   logic [31:0] raw_value;
   logic [31:0] conv_value;
   logic        range_value;

   rits_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register only blocks when it holds an item that is stalled.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_no_more_chars;
      end
   end

   rits_scan #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .char_code       (in_char_ff),
      .at_end          (in_end_ff),
      .radix           (cfg.radix),
      .max_field_width (cfg.max_field_width),
      .emit            (emit),
      .info            (info),
      .acc_value       (acc_value)
   );

   // Sign and saturation rules are applied on the way into the result register.
   rits_convert #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_convert (
      .acc_value       (acc_value),
      .info            (info),
      .result_mode     (cfg.result_mode),
      .raw_magnitude   (raw_value),
      .converted_value (conv_value),
      .range_error     (range_value)
   );

   assign out_valid_in = (fire && emit) ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         raw_ff   <= raw_value;
         conv_ff  <= conv_value;
         sign_ff  <= info.minus;
         ovf_ff   <= info.overflow;
         range_ff <= range_value;
         ok_ff    <= info.ok;
         count_ff <= info.count;
         stop_ff  <= info.stop_char;
         end_ff   <= info.at_end;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_raw_magnitude   = raw_ff;
   assign rsp_converted_value = conv_ff;
   assign rsp_sign_seen       = sign_ff;
   assign rsp_overflowed      = ovf_ff;
   assign rsp_range_error     = range_ff;
   assign rsp_valid_number    = ok_ff;
   assign rsp_chars_consumed  = count_ff;
   assign rsp_stop_char       = stop_ff;
   assign rsp_stopped_at_end  = end_ff;

endmodule

`default_nettype wire
